// ----- rtl/core/mps_pkg.sv -----
// Shared types and codes for the pipeline memory stage.
package mps_pkg;

    localparam logic [1:0] OP_STEP    = 2'd0;
    localparam logic [1:0] OP_END     = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [2:0] STAT_AOK = 3'd0;
    localparam logic [2:0] STAT_ADR = 3'd2;

    localparam logic [3:0] I_RRMOVL = 4'd2;
    localparam logic [3:0] I_IRMOVL = 4'd3;
    localparam logic [3:0] I_RMMOVL = 4'd4;
    localparam logic [3:0] I_MRMOVL = 4'd5;
    localparam logic [3:0] I_OPL    = 4'd6;
    localparam logic [3:0] I_JXX    = 4'd7;
    localparam logic [3:0] I_CALL   = 4'd8;
    localparam logic [3:0] I_RET    = 4'd9;
    localparam logic [3:0] I_PUSHL  = 4'd10;
    localparam logic [3:0] I_POPL   = 4'd11;

    localparam logic [3:0] REG_NONE = 4'd15;

    typedef struct packed {
        logic [1:0]         op;
        logic [2:0]         in_stat;
        logic [3:0]         in_icode;
        logic               in_cnd;
        logic signed [31:0] in_val_e;
        logic signed [31:0] in_val_a;
        logic [3:0]         in_dst_e;
        logic [3:0]         in_dst_m;
    } mps_item_t;

    typedef struct packed {
        logic               wb_valid;
        logic [2:0]         out_stat;
        logic [3:0]         out_icode;
        logic [3:0]         out_dst_e;
        logic [3:0]         out_dst_m;
        logic signed [31:0] out_val_e;
        logic signed [31:0] out_val_m;
        logic               fwd_e_valid;
        logic               fwd_m_valid;
        logic               jump_info_valid;
        logic               out_cnd;
        logic signed [31:0] out_val_a;
    } mps_result_t;

endpackage

// ----- rtl/core/pipeline_memory_stage_unit.sv -----
// Memory stage of a five-stage pipeline: data memory, load/store and result formatting.
//
// Usage: one word per instruction enters on the item channel (valid/ready) and one
// result word leaves on the result channel (valid/ready) for every word accepted,
// including end-of-program and restart words, whose results are empty.
// The word is registered together with the synchronous read of the data memory and
// of the written-flag memory; the writeback, forwarding and jump fields are then formed
// from it into the output register.
// Throughput is one word per cycle unless stalled or clearing; both memories are read and written
// once per cycle at the accept edge, so a load sees every store that came before it.
// The written flags live in a memory of MEM_WORDS entries. After reset, and after
// each accepted restart word, a clearing pass walks that memory one entry per cycle,
// during which item_ready stays low.
// When the receiver stalls, the result register holds its word and the inner stage
// holds too; outside the clearing pass, item_ready drops only once both stages are occupied.
// Reset clears the pipeline valids and the end-of-program flag and starts the
// clearing pass; data memory contents are not reset.
module pipeline_memory_stage_unit #(
    parameter int MEM_WORDS = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  mps_pkg::mps_item_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output mps_pkg::mps_result_t result
);
    import mps_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);

    logic [31:0]        data_mem [MEM_WORDS];
    logic               written_mem [MEM_WORDS];

    logic               program_ended_reg;
    logic               clr_active_reg;
    logic [AW-1:0]      clr_idx_reg;

    logic               s1_valid_reg;
    mps_item_t          s1_item_reg;
    logic               s1_active_reg;
    logic               s1_addr_ok_reg;
    logic [31:0]        rd_data_reg;
    logic               rd_written_reg;

    logic               result_valid_reg;
    mps_result_t        result_reg;
    mps_result_t        result_next;

    logic               accept;
    logic               s1_adv;
    logic               active;
    logic               do_store;
    logic [31:0]        ld_addr;
    logic [31:0]        st_addr;
    logic               ld_addr_ok;
    logic               st_addr_ok;
    logic               wf_we;
    logic [AW-1:0]      wf_addr;
    logic               wf_data;

    assign s1_adv     = s1_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !clr_active_reg && (!s1_valid_reg || s1_adv);
    assign accept     = item_valid && item_ready;

    assign active  = (item.op == OP_STEP) && !program_ended_reg;
    assign st_addr = $unsigned(item.in_val_e);
    assign ld_addr = (item.in_icode == I_MRMOVL) ? $unsigned(item.in_val_e)
                                                 : $unsigned(item.in_val_a);
    assign ld_addr_ok = ld_addr < 32'(MEM_WORDS);
    assign st_addr_ok = st_addr < 32'(MEM_WORDS);

    always_comb
    begin
        do_store = accept && active && (item.in_stat == STAT_AOK) && st_addr_ok
                   && (item.in_icode inside {I_RMMOVL, I_CALL, I_PUSHL});
    end

    // The clearing pass and stores never coincide: no word is taken while clearing.
    assign wf_we   = clr_active_reg || do_store;
    assign wf_addr = clr_active_reg ? clr_idx_reg : st_addr[AW-1:0];
    assign wf_data = !clr_active_reg;

    always_ff @(posedge clk)
    begin
        if (do_store)
        begin
            data_mem[st_addr[AW-1:0]] <= $unsigned(item.in_val_a);
        end
        if (accept)
        begin
            rd_data_reg <= data_mem[ld_addr[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wf_we)
        begin
            written_mem[wf_addr] <= wf_data;
        end
        if (accept)
        begin
            rd_written_reg <= written_mem[ld_addr[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg    <= item;
            s1_active_reg  <= active;
            s1_addr_ok_reg <= ld_addr_ok;
        end
        if (s1_adv)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            program_ended_reg <= 1'b0;
            clr_active_reg    <= 1'b1;
            clr_idx_reg       <= '0;
            s1_valid_reg      <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept && item.op == OP_END)
            begin
                program_ended_reg <= 1'b1;
            end
            else if (accept && item.op == OP_RESTART)
            begin
                program_ended_reg <= 1'b0;
            end

            if (accept && item.op == OP_RESTART)
            begin
                clr_active_reg <= 1'b1;
                clr_idx_reg    <= '0;
            end
            else if (clr_active_reg)
            begin
                if (clr_idx_reg == AW'(MEM_WORDS - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        logic fe;
        logic fm;
        logic wm;
        logic is_load;
        logic load_ok;

        fe      = 1'b0;
        fm      = 1'b0;
        wm      = 1'b0;
        is_load = 1'b0;

        result_next           = '0;
        result_next.out_dst_e = REG_NONE;
        result_next.out_dst_m = REG_NONE;

        case (s1_item_reg.in_icode)
            I_RRMOVL, I_IRMOVL, I_OPL:
            begin
                fe = 1'b1;
            end
            I_MRMOVL:
            begin
                is_load = 1'b1;
                fm      = 1'b1;
            end
            I_CALL, I_PUSHL:
            begin
                fe = 1'b1;
            end
            I_RET:
            begin
                is_load = 1'b1;
                fe      = 1'b1;
                wm      = 1'b1;
            end
            I_POPL:
            begin
                is_load = 1'b1;
                fe      = 1'b1;
                fm      = 1'b1;
            end
            default:
            begin
                fe = 1'b0;
            end
        endcase

        load_ok = !is_load || (s1_addr_ok_reg && rd_written_reg);

        if (s1_active_reg)
        begin
            result_next.wb_valid = 1'b1;
            result_next.out_stat = s1_item_reg.in_stat;
            if (s1_item_reg.in_stat == STAT_AOK)
            begin
                if (!load_ok)
                begin
                    result_next.out_stat = STAT_ADR;
                end
                else
                begin
                    result_next.out_icode   = s1_item_reg.in_icode;
                    result_next.fwd_e_valid = fe;
                    result_next.fwd_m_valid = fm;
                    if (fe)
                    begin
                        result_next.out_dst_e = s1_item_reg.in_dst_e;
                        result_next.out_val_e = s1_item_reg.in_val_e;
                    end
                    if (fm)
                    begin
                        result_next.out_dst_m = s1_item_reg.in_dst_m;
                    end
                    if (fm || wm)
                    begin
                        result_next.out_val_m = $signed(rd_data_reg);
                    end
                    if (s1_item_reg.in_icode == I_JXX)
                    begin
                        result_next.jump_info_valid = 1'b1;
                        result_next.out_cnd         = s1_item_reg.in_cnd;
                        result_next.out_val_a       = s1_item_reg.in_val_a;
                    end
                end
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- rtl/core/mps_checker.sv -----
// Port-level checks for the pipeline memory stage, bound to the top level.
module mps_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 item_ready,
    input  mps_pkg::mps_item_t   item,
    input  logic                 result_valid,
    input  logic                 result_ready,
    input  mps_pkg::mps_result_t result
);
    import mps_pkg::*;

    // A stalled result word must hold.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // The memory clearing pass starts straight out of reset, so no word is taken.
    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !item_ready)
        else $error("item taken during clearing after reset");

    // An empty result carries nothing but the default fields.
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.wb_valid |->
            !result.fwd_e_valid && !result.fwd_m_valid && !result.jump_info_valid
            && result.out_dst_e == REG_NONE && result.out_dst_m == REG_NONE)
        else $error("empty result carries fields");

    // Forwarding and jump info appear only with a good status.
    a_bad_stat_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.out_stat != STAT_AOK |->
            !result.fwd_e_valid && !result.fwd_m_valid && !result.jump_info_valid)
        else $error("forwarding or jump info with a bad status");

    // Jump info belongs to a jump instruction.
    a_jump_icode: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.jump_info_valid |-> result.out_icode == I_JXX)
        else $error("jump info without a jump instruction");

endmodule

bind pipeline_memory_stage_unit mps_checker u_mps_checker (.*);

// ----- test/pipeline_memory_stage_unit_tb.sv -----
// Self-checking testbench for the pipeline memory stage: random and directed words, checked against a predictor.
module pipeline_memory_stage_unit_tb;
    import mps_pkg::*;

    localparam int unsigned MEM_DEPTH = 1024;
    localparam int unsigned HOLD_CYCLES = 120;
    localparam int unsigned TARGET_STEPS = 1500;

    localparam logic [1:0] OP_BAD = 2'd3;
    localparam logic [2:0] STAT_HLT = 3'd1;
    localparam logic [2:0] STAT_INS = 3'd3;
    localparam logic [2:0] STAT_BUB = 3'd4;
    localparam logic [3:0] I_HALT = 4'd0;
    localparam logic [3:0] I_NOP = 4'd1;
    localparam logic [3:0] I_SPARE = 4'd15;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    mps_item_t item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    mps_result_t result;

    // Predictor state.
    logic [31:0] data_mem [MEM_DEPTH];
    bit word_valid [MEM_DEPTH];
    bit halted_flag;

    mps_item_t pending_items[$];
    mps_result_t expected_results[$];
    mps_result_t oldest_expected;

    bit quiet;
    bit hold_request;
    int unsigned hold_left;
    int unsigned send_gap;
    int unsigned recv_gap;
    int errors;
    int words_sent;
    int results_checked;
    int live_steps;
    int restarts;

    pipeline_memory_stage_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #5 clk = ~clk;

    function automatic void mem_write(logic [31:0] addr, logic [31:0] data);
        if (addr < MEM_DEPTH)
        begin
            data_mem[addr[9:0]] = data;
            word_valid[addr[9:0]] = 1'b1;
        end
    endfunction

    function automatic bit mem_read(logic [31:0] addr, output logic [31:0] data);
        data = '0;
        if (addr >= MEM_DEPTH || !word_valid[addr[9:0]])
            return 1'b0;
        data = data_mem[addr[9:0]];
        return 1'b1;
    endfunction

    function automatic mps_result_t memory_stage_predict(mps_item_t w);
        mps_result_t r;
        logic [31:0] loaded;
        bit hit;
        bit fwd_e;
        bit fwd_m;
        bit ret_load;
        r = '0;
        r.out_dst_e = REG_NONE;
        r.out_dst_m = REG_NONE;
        loaded = '0;
        hit = 1'b1;
        fwd_e = 1'b0;
        fwd_m = 1'b0;
        ret_load = 1'b0;
        if (w.op == OP_END)
        begin
            halted_flag = 1'b1;
            return r;
        end
        if (w.op == OP_RESTART)
        begin
            halted_flag = 1'b0;
            foreach (word_valid[i])
                word_valid[i] = 1'b0;
            return r;
        end
        if (w.op != OP_STEP || halted_flag)
            return r;
        r.wb_valid = 1'b1;
        r.out_stat = w.in_stat;
        if (w.in_stat != STAT_AOK)
            return r;
        case (w.in_icode)
            I_RRMOVL, I_IRMOVL, I_OPL: fwd_e = 1'b1;
            I_RMMOVL: mem_write(w.in_val_e, w.in_val_a);
            I_MRMOVL:
            begin
                hit = mem_read(w.in_val_e, loaded);
                fwd_m = 1'b1;
            end
            I_CALL, I_PUSHL:
            begin
                mem_write(w.in_val_e, w.in_val_a);
                fwd_e = 1'b1;
            end
            I_RET:
            begin
                hit = mem_read(w.in_val_a, loaded);
                fwd_e = 1'b1;
                ret_load = 1'b1;
            end
            I_POPL:
            begin
                hit = mem_read(w.in_val_a, loaded);
                fwd_e = 1'b1;
                fwd_m = 1'b1;
            end
            default: ;
        endcase
        if (!hit)
        begin
            r.out_stat = STAT_ADR;
            return r;
        end
        r.out_icode = w.in_icode;
        if (fwd_e)
        begin
            r.out_dst_e = w.in_dst_e;
            r.out_val_e = w.in_val_e;
        end
        // A return loads its target but forwards nothing from memory.
        if (fwd_m)
            r.out_dst_m = w.in_dst_m;
        if (fwd_m || ret_load)
            r.out_val_m = loaded;
        r.fwd_e_valid = fwd_e;
        r.fwd_m_valid = fwd_m;
        if (w.in_icode == I_JXX)
        begin
            r.jump_info_valid = 1'b1;
            r.out_cnd = w.in_cnd;
            r.out_val_a = w.in_val_a;
        end
        return r;
    endfunction

    function automatic mps_item_t make_word(logic [1:0] op, logic [2:0] st, logic [3:0] ic,
                                            logic c, logic [31:0] ve, logic [31:0] va,
                                            logic [3:0] de, logic [3:0] dm);
        mps_item_t w;
        w.op = op;
        w.in_stat = st;
        w.in_icode = ic;
        w.in_cnd = c;
        w.in_val_e = ve;
        w.in_val_a = va;
        w.in_dst_e = de;
        w.in_dst_m = dm;
        return w;
    endfunction

    // Mostly a handful of low addresses so that loads find earlier stores.
    function automatic logic [31:0] pick_addr();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, MEM_DEPTH - 1);
            2: return MEM_DEPTH + 1 - $urandom_range(0, 2);
            default: return $urandom_range(0, 15);
        endcase
    endfunction

    function automatic mps_item_t random_step();
        mps_item_t w;
        int unsigned pick;
        w.op = OP_STEP;
        case ($urandom_range(0, 19))
            0: w.in_stat = STAT_HLT;
            1: w.in_stat = STAT_ADR;
            2: w.in_stat = STAT_INS;
            3: w.in_stat = STAT_BUB;
            default: w.in_stat = STAT_AOK;
        endcase
        w.in_cnd = 1'($urandom);
        w.in_val_e = $urandom;
        w.in_val_a = $urandom;
        w.in_dst_e = 4'($urandom);
        w.in_dst_m = 4'($urandom);
        pick = $urandom_range(0, 9);
        if (pick < 3)
        begin
            case ($urandom_range(0, 2))
                0: w.in_icode = I_RMMOVL;
                1: w.in_icode = I_CALL;
                default: w.in_icode = I_PUSHL;
            endcase
            w.in_val_e = pick_addr();
        end
        else if (pick < 6)
        begin
            case ($urandom_range(0, 2))
                0: w.in_icode = I_MRMOVL;
                1: w.in_icode = I_RET;
                default: w.in_icode = I_POPL;
            endcase
            if (w.in_icode == I_MRMOVL)
                w.in_val_e = pick_addr();
            else
                w.in_val_a = pick_addr();
        end
        else
            w.in_icode = 4'($urandom);
        return w;
    endfunction

    // A run of live instructions, sometimes closed by a restart, which may follow an end of program.
    task automatic queue_program(int steps);
        mps_item_t w;
        int live;
        live = 0;
        while (live < steps)
        begin
            w = random_step();
            if ($urandom_range(0, 39) == 0)
                w.op = OP_BAD;
            else
                live++;
            pending_items.push_back(w);
        end
        live_steps += steps;
        case ($urandom_range(0, 3))
            0:
            begin
                w = random_step();
                w.op = OP_END;
                pending_items.push_back(w);
                repeat ($urandom_range(0, 3))
                    pending_items.push_back(random_step());
                w = random_step();
                w.op = OP_RESTART;
                pending_items.push_back(w);
                restarts++;
            end
            1:
            begin
                w = random_step();
                w.op = OP_RESTART;
                pending_items.push_back(w);
                restarts++;
            end
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endtask

    // Sender: a word on offer is held until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                expected_results.push_back(memory_stage_predict(item));
                words_sent++;
            end
            if (item_valid && !item_ready)
                ;
            else if (send_gap != 0)
            begin
                item_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_items.size() != 0 && !quiet && $urandom_range(0, 5) == 0)
            begin
                item_valid <= 1'b0;
                send_gap <= $urandom_range(0, 3);
            end
            else if (pending_items.size() != 0)
            begin
                item_valid <= 1'b1;
                item <= pending_items.pop_front();
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Long receiver hold-off, counted here so the sender keeps offering meanwhile.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_request)
            hold_left <= HOLD_CYCLES;
    end

    // Receiver and checker.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word arrived with nothing expected");
                    errors++;
                end
                else
                begin
                    oldest_expected = expected_results.pop_front();
                    check_field("wb_valid", 32'(oldest_expected.wb_valid), 32'(result.wb_valid));
                    check_field("out_stat", 32'(oldest_expected.out_stat), 32'(result.out_stat));
                    check_field("out_icode", 32'(oldest_expected.out_icode),
                                32'(result.out_icode));
                    check_field("out_dst_e", 32'(oldest_expected.out_dst_e),
                                32'(result.out_dst_e));
                    check_field("out_dst_m", 32'(oldest_expected.out_dst_m),
                                32'(result.out_dst_m));
                    check_field("out_val_e", oldest_expected.out_val_e, result.out_val_e);
                    check_field("out_val_m", oldest_expected.out_val_m, result.out_val_m);
                    check_field("fwd_e_valid", 32'(oldest_expected.fwd_e_valid),
                                32'(result.fwd_e_valid));
                    check_field("fwd_m_valid", 32'(oldest_expected.fwd_m_valid),
                                32'(result.fwd_m_valid));
                    check_field("jump_info_valid", 32'(oldest_expected.jump_info_valid),
                                32'(result.jump_info_valid));
                    check_field("out_cnd", 32'(oldest_expected.out_cnd), 32'(result.out_cnd));
                    check_field("out_val_a", oldest_expected.out_val_a, result.out_val_a);
                    results_checked++;
                end
            end
            if (hold_left != 0)
                result_ready <= 1'b0;
            else if (recv_gap != 0)
            begin
                result_ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                result_ready <= 1'b0;
                recv_gap <= $urandom_range(0, 3);
            end
            else
                result_ready <= 1'b1;
        end
    end

    initial
    begin
        #3000000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        foreach (word_valid[i])
            word_valid[i] = 1'b0;
        halted_flag = 1'b0;
        quiet = 1'b0;
        hold_request = 1'b0;
        errors = 0;
        words_sent = 0;
        results_checked = 0;
        live_steps = 0;
        restarts = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Stores at both ends of memory and one beyond it, then loads of each kind, then moves, jumps and other codes.
        pending_items.push_back(make_word(OP_STEP, STAT_AOK, I_RMMOVL, 1'b0, 32'd0,
                                          32'h7FFF_FFFF, 4'd0, 4'd1));
        pending_items.push_back(make_word(OP_STEP, STAT_AOK, I_PUSHL, 1'b1, MEM_DEPTH - 1,
                                          32'h8000_0000, 4'd4, REG_NONE));
        pending_items.push_back(make_word(OP_STEP, STAT_AOK, I_CALL, 1'b0, 32'd5,
                                          32'hFFFF_FFFF, 4'd4, REG_NONE));
        pending_items.push_back(make_word(OP_STEP, STAT_AOK, I_RMMOVL, 1'b0, MEM_DEPTH,
                                          32'h1234_5678, REG_NONE, REG_NONE));
        pending_items.push_back(make_word(OP_STEP, STAT_AOK, I_MRMOVL, 1'b0, 32'd0,
                                          32'd0, REG_NONE, 4'd3));
        pending_items.push_back(make_word(OP_STEP, STAT_AOK, I_POPL, 1'b1, 32'd8,
                                          MEM_DEPTH - 1, 4'd4, 4'd6));
        pending_items.push_back(make_word(OP_STEP, STAT_AOK, I_RET, 1'b0, 32'd9,
                                          32'd5, 4'd4, REG_NONE));
        pending_items.push_back(make_word(OP_STEP, STAT_AOK, I_MRMOVL, 1'b0, MEM_DEPTH,
                                          32'd0, REG_NONE, 4'd2));
        pending_items.push_back(make_word(OP_STEP, STAT_AOK, I_MRMOVL, 1'b0, 32'd7,
                                          32'd0, REG_NONE, 4'd2));
        pending_items.push_back(make_word(OP_STEP, STAT_AOK, I_POPL, 1'b0, 32'd4,
                                          32'hFFFF_FFFF, 4'd4, 4'd7));
        pending_items.push_back(make_word(OP_STEP, STAT_AOK, I_RRMOVL, 1'b0, 32'h8000_0000,
                                          32'h7FFF_FFFF, 4'd1, REG_NONE));
        pending_items.push_back(make_word(OP_STEP, STAT_AOK, I_IRMOVL, 1'b1, 32'h7FFF_FFFF,
                                          32'd0, 4'd14, REG_NONE));
        pending_items.push_back(make_word(OP_STEP, STAT_AOK, I_OPL, 1'b0, 32'hFFFF_FFFF,
                                          32'h8000_0000, 4'd0, 4'd15));
        pending_items.push_back(make_word(OP_STEP, STAT_AOK, I_JXX, 1'b1, 32'd0,
                                          32'h8000_0000, REG_NONE, REG_NONE));
        pending_items.push_back(make_word(OP_STEP, STAT_AOK, I_JXX, 1'b0, 32'hFFFF_FFFF,
                                          32'h7FFF_FFFF, REG_NONE, REG_NONE));
        pending_items.push_back(make_word(OP_STEP, STAT_AOK, I_HALT, 1'b1, 32'd1,
                                          32'd2, 4'd3, 4'd4));
        pending_items.push_back(make_word(OP_STEP, STAT_AOK, I_NOP, 1'b0, 32'd1,
                                          32'd2, 4'd3, 4'd4));
        pending_items.push_back(make_word(OP_STEP, STAT_AOK, I_SPARE, 1'b1, 32'hFFFF_FFFF,
                                          32'hFFFF_FFFF, 4'd15, 4'd15));
        // Bad status leaves memory alone, even for a store.
        pending_items.push_back(make_word(OP_STEP, STAT_HLT, I_RMMOVL, 1'b0, 32'd2,
                                          32'd99, 4'd1, 4'd1));
        pending_items.push_back(make_word(OP_STEP, STAT_ADR, I_MRMOVL, 1'b1, 32'd0,
                                          32'd0, 4'd1, 4'd1));
        pending_items.push_back(make_word(OP_STEP, STAT_INS, I_POPL, 1'b0, 32'd0,
                                          32'd0, 4'd1, 4'd1));
        pending_items.push_back(make_word(OP_STEP, STAT_BUB, I_JXX, 1'b1, 32'd0,
                                          32'd0, 4'd1, 4'd1));
        pending_items.push_back(make_word(OP_BAD, STAT_AOK, I_RMMOVL, 1'b1, 32'd3,
                                          32'd3, 4'd1, 4'd1));
        // After end of program a store is dropped; restart forgets every written word.
        pending_items.push_back(make_word(OP_END, STAT_AOK, I_NOP, 1'b0, 32'd0,
                                          32'd0, REG_NONE, REG_NONE));
        pending_items.push_back(make_word(OP_STEP, STAT_AOK, I_RMMOVL, 1'b0, 32'd2,
                                          32'd77, REG_NONE, REG_NONE));
        pending_items.push_back(make_word(OP_RESTART, STAT_AOK, I_NOP, 1'b0, 32'd0,
                                          32'd0, REG_NONE, REG_NONE));
        pending_items.push_back(make_word(OP_STEP, STAT_AOK, I_MRMOVL, 1'b0, 32'd0,
                                          32'd0, REG_NONE, 4'd5));
        restarts = 1;
        wait_idle();

        // Receiver holds off while the sender keeps offering, so the stage fills up.
        repeat (40)
            pending_items.push_back(random_step());
        live_steps += 40;
        hold_request = 1'b1;
        while (hold_left == 0)
            @(negedge clk);
        hold_request = 1'b0;
        wait_idle();

        while (live_steps < TARGET_STEPS - 100)
        begin
            while (pending_items.size() > 4)
                @(negedge clk);
            quiet = ($urandom_range(0, 4) == 0);
            queue_program($urandom_range(20, 100));
            // Now and then the sender waits for the stage to empty completely.
            if ($urandom_range(0, 5) == 0)
                wait_idle();
        end

        wait_idle();
        quiet = 1'b1;
        queue_program(100);
        wait_idle();
        repeat (20) @(negedge clk);

        $display("Accepted %0d words (%0d live instructions, %0d restarts), checked %0d results.",
                 words_sent, live_steps, restarts, results_checked);
        $display("Covered stores, loads, address errors, bad status, jumps, end and restart.");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
